[rtl/core/fbs_pkg.sv]
package fbs_pkg;

   localparam int unsigned KeyWidth    = 8;
   localparam int unsigned SampleWidth = 8;
   localparam int unsigned FanCount    = 3;
   localparam int unsigned StepWidth   = 4;
   localparam int unsigned SecWidth    = 8;
   localparam int unsigned CsrWidth    = 8;

   localparam logic [KeyWidth-1:0] KeyZero  = 8'h30;
   localparam logic [KeyWidth-1:0] KeyOne   = 8'h31;
   localparam logic [KeyWidth-1:0] KeyThree = 8'h33;
   localparam logic [KeyWidth-1:0] KeyStar  = 8'h2A;
   localparam logic [KeyWidth-1:0] KeyHash  = 8'h23;
   localparam logic [KeyWidth-1:0] KeyProgA = 8'h41;
   localparam logic [KeyWidth-1:0] KeyProgB = 8'h42;

   localparam logic [SampleWidth-1:0] SampleAllOne  = 8'hFF;
   localparam logic [SampleWidth-1:0] SampleAllZero = 8'h00;
   localparam logic [SecWidth-1:0]    SecMax        = 8'hFF;

   localparam logic [CsrWidth-1:0] RotateReset = 8'd7;
   localparam logic [CsrWidth-1:0] SpinupReset = 8'd3;

   typedef enum logic {
      CsrRotate = 1'b0,
      CsrSpinup = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ProgNone = 2'd0,
      ProgA    = 2'd1,
      ProgB    = 2'd2
   } prog_type;

   typedef enum logic [1:0] {
      RptOff   = 2'd0,
      RptOk    = 2'd1,
      RptError = 2'd2
   } report_type;

   typedef enum logic {
      KindPoll = 1'b0,
      KindTick = 1'b1
   } kind_type;

   typedef struct packed {
      logic                   kind;
      logic [KeyWidth-1:0]    key_code;
      logic [SampleWidth-1:0] samples_fan1;
      logic [SampleWidth-1:0] samples_fan2;
      logic [SampleWidth-1:0] samples_fan3;
   } item_type;

   typedef struct packed {
      logic [FanCount-1:0] fan_drive;
      logic [1:0]          report_fan1;
      logic [1:0]          report_fan2;
      logic [1:0]          report_fan3;
      logic                program_active;
   } result_type;

   function automatic logic sample_ok(input logic [SampleWidth-1:0] s);
      return (s != SampleAllOne) && (s != SampleAllZero);
   endfunction

   function automatic logic [1:0] report_code(input logic on, input logic ok);
      report_code = RptOff;
      if (on) begin
         report_code = ok ? RptOk : RptError;
      end
   endfunction

endpackage

[rtl/core/fbs_req_if.sv]
interface fbs_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] key_code;
   logic [7:0] samples_fan1;
   logic [7:0] samples_fan2;
   logic [7:0] samples_fan3;

   modport source (output valid, kind, key_code, samples_fan1, samples_fan2, samples_fan3,
                   input ready);
   modport sink   (input valid, kind, key_code, samples_fan1, samples_fan2, samples_fan3,
                   output ready);
endinterface

[rtl/core/fbs_rsp_if.sv]
interface fbs_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] fan_drive;
   logic [1:0] report_fan1;
   logic [1:0] report_fan2;
   logic [1:0] report_fan3;
   logic       program_active;

   modport source (output valid, fan_drive, report_fan1, report_fan2, report_fan3,
                   program_active, input ready);
   modport sink   (input valid, fan_drive, report_fan1, report_fan2, report_fan3,
                   program_active, output ready);
endinterface

[rtl/core/fan_bank_sequencer_top.sv]
// Channel   Dir  Payload                                              Handshake
// req_ch    in   kind, key_code, samples_fan1..3                      valid/ready
// rsp_ch    out  fan_drive, report_fan1..3, program_active            valid/ready
// csr_*     in   csr_index selects rotate/spinup, csr_wdata           csr_we, no wait
//
// One transfer per cycle while req_ch.ready is high; a result appears in the cycle after its request transfer.
// Fan state updates on the request transfer; the result register holds the outcome.
// req_ch.ready is high while the result register is empty or being drained.
// Synchronous active-high reset clears fan state and loads period defaults 7 and 3.
module fan_bank_sequencer_top
   import fbs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   fbs_req_if.sink             req_ch,
   fbs_rsp_if.source           rsp_ch,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [CsrWidth-1:0] csr_wdata
);

   logic [CsrWidth-1:0] rotate_ff;
   logic [CsrWidth-1:0] spinup_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          rsp_data_ff;
   result_type          result;
   item_type            item;
   logic                take;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign take         = req_ch.valid && req_ch.ready;
   assign rsp_valid_in = take || (rsp_valid_ff && !rsp_ch.ready);

   assign item.kind         = req_ch.kind;
   assign item.key_code     = req_ch.key_code;
   assign item.samples_fan1 = req_ch.samples_fan1;
   assign item.samples_fan2 = req_ch.samples_fan2;
   assign item.samples_fan3 = req_ch.samples_fan3;

   fbs_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .take           (take),
      .item           (item),
      .rotate_seconds (rotate_ff),
      .spinup_seconds (spinup_ff),
      .result         (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rotate_ff <= RotateReset;
         spinup_ff <= SpinupReset;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CsrRotate: rotate_ff <= csr_wdata;
            CsrSpinup: spinup_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.fan_drive      = rsp_data_ff.fan_drive;
   assign rsp_ch.report_fan1    = rsp_data_ff.report_fan1;
   assign rsp_ch.report_fan2    = rsp_data_ff.report_fan2;
   assign rsp_ch.report_fan3    = rsp_data_ff.report_fan3;
   assign rsp_ch.program_active = rsp_data_ff.program_active;

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      take |-> !(rsp_valid_ff && !rsp_ch.ready))
      else $error("request transfer while result register is stalled");

   a_report_matches_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (((rsp_ch.report_fan1 == RptOff) == !rsp_ch.fan_drive[0]) &&
                        ((rsp_ch.report_fan2 == RptOff) == !rsp_ch.fan_drive[1]) &&
                        ((rsp_ch.report_fan3 == RptOff) == !rsp_ch.fan_drive[2])))
      else $error("fan report disagrees with fan drive");

   a_result_follows_transfer: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid_ff)
      else $error("result missing after request transfer");

endmodule

[rtl/core/fbs_ctrl.sv]
module fbs_ctrl
   import fbs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  item_type            item,
   input  logic [CsrWidth-1:0] rotate_seconds,
   input  logic [CsrWidth-1:0] spinup_seconds,
   output result_type          result
);

   localparam logic [StepWidth-1:0] StepStart  = 4'd0;
   localparam logic [StepWidth-1:0] StepAFan1  = 4'd1;
   localparam logic [StepWidth-1:0] StepAFan2  = 4'd3;
   localparam logic [StepWidth-1:0] StepAFan3  = 4'd5;
   localparam logic [StepWidth-1:0] StepAWrap  = 4'd7;
   localparam logic [StepWidth-1:0] StepBHold1 = 4'd2;
   localparam logic [StepWidth-1:0] StepBHold2 = 4'd5;
   localparam logic [StepWidth-1:0] StepBHold3 = 4'd8;
   localparam logic [StepWidth-1:0] StepBChk1  = 4'd3;
   localparam logic [StepWidth-1:0] StepBChk2  = 4'd6;
   localparam logic [StepWidth-1:0] StepBLast  = 4'd9;

   logic [FanCount-1:0]  drive_ff,   drive_in;
   logic [KeyWidth-1:0]  prev_key_ff, prev_key_in;
   logic                 locked_ff,  locked_in;
   prog_type             prog_ff,    prog_in;
   logic [StepWidth-1:0] step_ff,    step_in;
   logic [SecWidth-1:0]  sec_ff,     sec_in;
   logic                 tick_en_ff, tick_en_in;
   logic [FanCount-1:0]  healthy_ff, healthy_in;

   always_comb begin
      logic [KeyWidth-1:0] key;
      logic [KeyWidth-1:0] key_off;
      key         = item.key_code;
      key_off     = key - KeyOne;
      drive_in    = drive_ff;
      prev_key_in = prev_key_ff;
      locked_in   = locked_ff;
      prog_in     = prog_ff;
      step_in     = step_ff;
      sec_in      = sec_ff;
      tick_en_in  = tick_en_ff;
      healthy_in  = healthy_ff;
      if (item.kind == KindTick) begin
         if (tick_en_ff) begin
            if (sec_ff != SecMax) begin
               sec_in = sec_ff + 8'd1;
            end
            if ((prog_ff == ProgA && sec_in >= rotate_seconds) ||
                (prog_ff == ProgB && sec_in >= spinup_seconds)) begin
               step_in = step_ff + 4'd1;
            end
         end
      end else begin
         if (locked_ff) begin
            if (key == KeyZero) begin
               locked_in  = 1'b0;
               drive_in   = '0;
               tick_en_in = 1'b0;
            end else if (prog_ff == ProgA) begin
               case (step_ff)
                  StepStart: begin
                     tick_en_in = 1'b1;
                     step_in    = step_ff + 4'd1;
                  end
                  StepAFan1: begin
                     sec_in   = '0;
                     drive_in = drive_ff | 3'b001;
                     step_in  = step_ff + 4'd1;
                  end
                  StepAFan2: begin
                     sec_in   = '0;
                     drive_in = (drive_ff & 3'b110) | 3'b010;
                     step_in  = step_ff + 4'd1;
                  end
                  StepAFan3: begin
                     sec_in   = '0;
                     drive_in = (drive_ff & 3'b101) | 3'b100;
                     step_in  = step_ff + 4'd1;
                  end
                  StepAWrap: begin
                     sec_in   = '0;
                     drive_in = (drive_ff & 3'b011) | 3'b001;
                     step_in  = StepAFan1;
                  end
                  default: ;
               endcase
            end else if (prog_ff == ProgB) begin
               case (step_ff) inside
                  StepStart: begin
                     drive_in   = drive_ff | 3'b001;
                     tick_en_in = 1'b1;
                     sec_in     = '0;
                     step_in    = step_ff + 4'd1;
                  end
                  StepBHold1, StepBHold2, StepBHold3: begin
                     tick_en_in = 1'b0;
                     step_in    = step_ff + 4'd1;
                  end
                  StepBChk1: begin
                     if (!healthy_ff[0]) begin
                        step_in    = step_ff + 4'd1;
                        drive_in   = (drive_ff & 3'b110) | 3'b010;
                        sec_in     = '0;
                        tick_en_in = 1'b1;
                     end
                  end
                  StepBChk2: begin
                     if (!healthy_ff[1]) begin
                        step_in    = step_ff + 4'd1;
                        drive_in   = (drive_ff & 3'b101) | 3'b100;
                        sec_in     = '0;
                        tick_en_in = 1'b1;
                     end
                  end
                  StepBLast: begin
                     if (!healthy_ff[2]) begin
                        drive_in = drive_ff & 3'b011;
                     end
                  end
                  default: ;
               endcase
            end
         end else if (key != prev_key_ff) begin
            if (key >= KeyOne && key <= KeyThree) begin
               drive_in = drive_ff ^ (3'b001 << key_off[1:0]);
            end else if (key == KeyStar) begin
               drive_in = 3'b111;
            end else if (key == KeyHash) begin
               drive_in = '0;
            end else if (key == KeyProgA || key == KeyProgB) begin
               drive_in  = '0;
               locked_in = 1'b1;
               prog_in   = (key == KeyProgA) ? ProgA : ProgB;
               step_in   = StepStart;
            end
         end
         healthy_in  = {sample_ok(item.samples_fan3), sample_ok(item.samples_fan2),
                        sample_ok(item.samples_fan1)};
         prev_key_in = key;
      end
   end

   always_comb begin
      result.fan_drive      = drive_in;
      result.report_fan1    = report_code(drive_in[0], healthy_in[0]);
      result.report_fan2    = report_code(drive_in[1], healthy_in[1]);
      result.report_fan3    = report_code(drive_in[2], healthy_in[2]);
      result.program_active = locked_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_ff    <= '0;
         prev_key_ff <= '0;
         locked_ff   <= 1'b0;
         prog_ff     <= ProgNone;
         step_ff     <= '0;
         sec_ff      <= '0;
         tick_en_ff  <= 1'b0;
         healthy_ff  <= '0;
      end else if (take) begin
         drive_ff    <= drive_in;
         prev_key_ff <= prev_key_in;
         locked_ff   <= locked_in;
         prog_ff     <= prog_in;
         step_ff     <= step_in;
         sec_ff      <= sec_in;
         tick_en_ff  <= tick_en_in;
         healthy_ff  <= healthy_in;
      end
   end

endmodule
